// File: sv/olir_pkg.sv
// Shared types, sizes and codes for the ordered list block.
// No dependencies; olir_if, olir_ctrl and the top level use this package.
`timescale 1ns / 1ps
`default_nettype none

package olir_pkg;

  localparam int DEPTH     = 64;
  localparam int ELEM_BITS = 32;

  localparam int FUNC_W    = 2;
  localparam int POS_W     = 7;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;

  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_GET    = 2'd0,
    FN_INSERT = 2'd1,
    FN_REMOVE = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [POS_W-1:0]    count_now;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [ELEM_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } ram_req_t;

  // Keep the low ELEM_BITS bits of an input word.
  function automatic logic [ELEM_BITS-1:0] elem_from_word(input logic [VALUE_W-1:0] w);
    logic [63:0] t;
    t = 64'(w);
    return t[ELEM_BITS-1:0];
  endfunction

  // Zero-extend or truncate an element to the output word.
  function automatic logic [VALUE_W-1:0] word_from_elem(input logic [ELEM_BITS-1:0] e);
    logic [63:0] t;
    t = 64'(e);
    return t[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/olir_if.sv
// Valid/ready channel interfaces for the ordered list block.
// Depends on olir_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface olir_in_if;
  logic                         valid;
  logic                         ready;
  logic [olir_pkg::FUNC_W-1:0]  func;
  logic [olir_pkg::POS_W-1:0]   position;
  logic [olir_pkg::VALUE_W-1:0] value_in;

  modport source (output valid, func, position, value_in, input ready);
  modport sink   (input valid, func, position, value_in, output ready);
endinterface

interface olir_out_if;
  logic                          valid;
  logic                          ready;
  logic [olir_pkg::STATUS_W-1:0] status;
  logic [olir_pkg::VALUE_W-1:0]  value_out;
  logic [olir_pkg::POS_W-1:0]    count_now;

  modport source (output valid, status, value_out, count_now, input ready);
  modport sink   (input valid, status, value_out, count_now, output ready);
endinterface

`default_nettype wire

// File: sv/olir_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module olir_ram #(
  parameter int DEPTH_P = 64,
  parameter int WIDTH_P = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH_P)-1:0] waddr_i,
  input  wire logic [WIDTH_P-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH_P)-1:0] raddr_i,
  output logic      [WIDTH_P-1:0]         rdata_o
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/olir_ctrl.sv
// Sequencer for the ordered list: decodes an operation, walks the shift
// through the entry RAM one element per cycle and keeps the count.
// Depends on olir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olir_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                req_valid_i,
  input  wire olir_pkg::in_t                       req_i,
  output logic                                     req_ready_o,
  output logic                                     res_valid_o,
  output olir_pkg::out_t                           res_o,
  input  wire logic                                res_take_i,
  output olir_pkg::ram_req_t                       ram_o,
  input  wire logic [olir_pkg::ELEM_BITS-1:0]      rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PUT   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                           state_q, state_d;
  logic [olir_pkg::FUNC_W-1:0]      op_q, op_d;
  logic [olir_pkg::ADDR_W-1:0]      pos_q, pos_d;
  logic [olir_pkg::ADDR_W-1:0]      idx_q, idx_d;
  logic [olir_pkg::ELEM_BITS-1:0]   val_q, val_d;
  logic [olir_pkg::CNT_W-1:0]       count_q, count_d;
  olir_pkg::status_e                status_q, status_d;
  logic [olir_pkg::VALUE_W-1:0]     rval_q, rval_d;

  logic [olir_pkg::CMP_W-1:0]       req_pos_c;
  logic [olir_pkg::CMP_W-1:0]       count_c;
  logic [olir_pkg::ELEM_BITS-1:0]   req_elem;

  assign req_pos_c = olir_pkg::CMP_W'(req_i.position);
  assign count_c   = olir_pkg::CMP_W'(count_q);
  assign req_elem  = olir_pkg::elem_from_word(req_i.value_in);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    val_d     = val_q;
    count_d   = count_q;
    status_d  = status_q;
    rval_d    = rval_q;
    ram_o.we    = 1'b0;
    ram_o.waddr = idx_q;
    ram_o.wdata = rdata_i;
    ram_o.raddr = pos_q;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_i.func;
          pos_d    = olir_pkg::ADDR_W'(req_i.position);
          val_d    = req_elem;
          status_d = olir_pkg::ST_RANGE;
          rval_d   = '0;
          state_d  = S_DONE;
          case (req_i.func)
            olir_pkg::FN_GET: begin
              if (req_pos_c < count_c) begin
                ram_o.raddr = olir_pkg::ADDR_W'(req_i.position);
                state_d     = S_RD;
              end
            end
            olir_pkg::FN_INSERT: begin
              if (req_pos_c > count_c) begin
                status_d = olir_pkg::ST_RANGE;
              end else if (count_q == olir_pkg::CNT_W'(olir_pkg::DEPTH)) begin
                status_d = olir_pkg::ST_FULL;
              end else if (req_pos_c == count_c) begin
                // append: no entries to move
                ram_o.we    = 1'b1;
                ram_o.waddr = olir_pkg::ADDR_W'(req_i.position);
                ram_o.wdata = req_elem;
                count_d     = count_q + 1'b1;
                status_d    = olir_pkg::ST_OK;
                rval_d      = olir_pkg::word_from_elem(req_elem);
              end else begin
                idx_d       = olir_pkg::ADDR_W'(count_q);
                ram_o.raddr = olir_pkg::ADDR_W'(count_q - 1'b1);
                state_d     = S_SHIFT;
              end
            end
            olir_pkg::FN_REMOVE: begin
              if (req_pos_c < count_c) begin
                ram_o.raddr = olir_pkg::ADDR_W'(req_i.position);
                state_d     = S_RD;
              end
            end
            default: begin
              status_d = olir_pkg::ST_RANGE;
            end
          endcase
        end
      end

      S_RD: begin
        rval_d   = olir_pkg::word_from_elem(rdata_i);
        status_d = olir_pkg::ST_OK;
        if (op_q == olir_pkg::FN_GET) begin
          state_d = S_DONE;
        end else if (olir_pkg::CNT_W'(pos_q) + 1'b1 == count_q) begin
          // removed the last element: nothing to close up
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end else begin
          ram_o.raddr = pos_q + 1'b1;
          idx_d       = pos_q;
          state_d     = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // rdata holds the neighbor of idx read in the previous cycle
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        ram_o.wdata = rdata_i;
        if (op_q == olir_pkg::FN_INSERT) begin
          if (idx_q - 1'b1 == pos_q) begin
            state_d = S_PUT;
          end else begin
            ram_o.raddr = idx_q - 2'd2;
            idx_d       = idx_q - 1'b1;
          end
        end else begin
          if (olir_pkg::CNT_W'(idx_q) + 2'd2 == count_q) begin
            count_d = count_q - 1'b1;
            state_d = S_DONE;
          end else begin
            ram_o.raddr = idx_q + 2'd2;
            idx_d       = idx_q + 1'b1;
          end
        end
      end

      S_PUT: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = pos_q;
        ram_o.wdata = val_q;
        count_d     = count_q + 1'b1;
        status_d    = olir_pkg::ST_OK;
        rval_d      = olir_pkg::word_from_elem(val_q);
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_ready_o     = (state_q == S_IDLE);
  assign res_valid_o     = (state_q == S_DONE);
  assign res_o.status    = status_q;
  assign res_o.value_out = rval_q;
  assign res_o.count_now = olir_pkg::POS_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    val_q    <= val_d;
    status_q <= status_d;
    rval_q   <= rval_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olir_pkg::CNT_W'(olir_pkg::DEPTH))
    else $error("count exceeds list depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1)))
    else $error("count moved by more than one");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == olir_pkg::ST_FULL) |->
      (count_q == olir_pkg::CNT_W'(olir_pkg::DEPTH)))
    else $error("full status with room left");

  a_shift_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=>
      (state_q == S_SHIFT || state_q == S_PUT || state_q == S_DONE))
    else $error("shift left to an unexpected state");

  a_shift_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && state_d == S_SHIFT) |-> (ram_o.raddr != ram_o.waddr))
    else $error("shift reads the entry it writes");

endmodule

`default_nettype wire

// File: sv/ordered_list_insert_remove.sv
// Ordered list with positional get, insert and remove: top level.
// Depends on olir_pkg, olir_if, olir_ram and olir_ctrl.
//
// Usage:
//   in_i carries one operation per beat: func (get, insert, remove),
//   position and value_in. out_o returns one beat per operation: status,
//   value_out and count_now (elements held after the operation).
//   The entries live in a RAM with one read and one write port; insert and
//   remove move the later entries one per cycle through that RAM.
//   States from accept to the result register, then on to out_o:
//     get, error or func 3 : error/func 3 direct; get via S_RD
//     insert at the end    : written at accept, then direct to the result
//     insert inside list   : S_SHIFT for each moved entry, then S_PUT
//     remove               : S_RD, then S_SHIFT unless the last element is removed
//   in_i.ready is high only while no operation is in progress, so one
//   operation at a time occupies the sequencer.
//   A finished result sits in the output register; the next operation is
//   accepted while it waits. If out_o.ready stays low, the following result
//   holds in the sequencer and in_i.ready drops until the register frees.
//   Reset empties the list (count zero); entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_remove (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  olir_in_if.sink   in_i,
  olir_out_if.source out_o
);

  olir_pkg::in_t                   req;
  olir_pkg::out_t                  res;
  olir_pkg::out_t                  out_q;
  olir_pkg::ram_req_t              ram_req;
  logic [olir_pkg::ELEM_BITS-1:0]  ram_rdata;
  logic                            res_valid;
  logic                            res_take;
  logic                            out_valid_q;

  assign req.func     = in_i.func;
  assign req.position = in_i.position;
  assign req.value_in = in_i.value_in;

  // load the output register when it is empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || out_o.ready);

  olir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_i       (req),
    .req_ready_o (in_i.ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .ram_o       (ram_req),
    .rdata_i     (ram_rdata)
  );

  olir_ram #(
    .DEPTH_P (olir_pkg::DEPTH),
    .WIDTH_P (olir_pkg::ELEM_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_q.status;
  assign out_o.value_out = out_q.value_out;
  assign out_o.count_now = out_q.count_now;

endmodule

`default_nettype wire
